[design/mcr_pkg.sv]
// Package for the midpoint circle rasterizer: opcodes, status codes, sequencer
// state and the pixel ordering tables shared by the design.
// No dependencies.
package mcr_pkg;

	// Opcodes carried in the input tuser.
	localparam logic [1:0] OP_START_FULL   = 2'd0;
	localparam logic [1:0] OP_START_CORNER = 2'd1;
	localparam logic [1:0] OP_STEP         = 2'd2;

	// Status codes carried in the output tuser.
	localparam logic [1:0] STS_PIXEL = 2'd0;
	localparam logic [1:0] STS_START = 2'd1;
	localparam logic [1:0] STS_DONE  = 2'd2;
	localparam logic [1:0] STS_BADR  = 2'd3;

	// Field widths.
	localparam int CoordW    = 16;
	localparam int RadiusW   = 15;
	localparam int PixW      = 17;
	localparam int ColorW    = 32;
	localparam int MaskW     = 4;
	localparam int DecisionW = 18;
	localparam int GradXW    = 16;
	localparam int GradYW    = 17;
	localparam int NumSlots  = 8;

	// Sequencer states, one-hot.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	// Which pixel ordering is being drained.
	typedef enum logic [1:0] {
		TBL_AXIS   = 2'd0,
		TBL_FULL   = 2'd1,
		TBL_CORNER = 2'd2
	} tbl_t;

	// Octant selector: swap picks (y,x) over (x,y), neg_a/neg_b negate the
	// column and row offsets.
	typedef struct packed {
		logic swap;
		logic neg_b;
		logic neg_a;
	} oct_t;

	// Maps a pending slot of a given table to the octant it draws.
	function automatic oct_t slot_oct(input tbl_t tbl, input logic [2:0] slot);
		logic [2:0] code;
		code = 3'd0;
		case (tbl)
			TBL_FULL: begin
				code = slot;
			end
			TBL_CORNER: begin
				case (slot)
					3'd0:    code = 3'd0;
					3'd1:    code = 3'd4;
					3'd2:    code = 3'd2;
					3'd3:    code = 3'd6;
					3'd4:    code = 3'd5;
					3'd5:    code = 3'd1;
					3'd6:    code = 3'd7;
					3'd7:    code = 3'd3;
					default: code = 3'd0;
				endcase
			end
			TBL_AXIS: begin
				case (slot)
					3'd0:    code = 3'd0;
					3'd1:    code = 3'd2;
					3'd2:    code = 3'd4;
					3'd3:    code = 3'd5;
					default: code = 3'd0;
				endcase
			end
			default: code = 3'd0;
		endcase
		return oct_t'(code);
	endfunction

endpackage

[design/midpoint_circle_rasterizer_top.sv]
// Midpoint circle rasterizer top level: input stream, decision update,
// pixel sequencer and output register.
// Depends on mcr_pkg.
//
// Each accepted beat is answered by its results one per cycle while the output
// register is not held by m_axis_tready low; pixels come from a single
// coordinate adder pair that builds one mirrored pixel per cycle. The input is
// not ready until the last result of the beat has been loaded into the output
// register. A full-circle start gives five results, a corner start or any
// status answer one, a step eight in full mode and two per selected quadrant in
// corner mode. A step in corner mode with an empty mask and the unused opcode
// produce no result. Every beat's final result carries tlast.
module midpoint_circle_rasterizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// center_x[15:0], center_y[31:16], radius[46:32], corner_mask[50:47],
	// color[82:51], zero pad[87:83]
	input  logic [87:0] s_axis_tdata,
	// opcode[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_x[16:0], pixel_y[33:17], pixel_color[65:34], zero pad[71:66]
	output logic [71:0] m_axis_tdata,
	// status[1:0]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	// Input field unpacking.
	logic        [1:0]                    in_op;
	logic signed [mcr_pkg::CoordW-1:0]    in_cx;
	logic signed [mcr_pkg::CoordW-1:0]    in_cy;
	logic signed [mcr_pkg::RadiusW-1:0]   in_r;
	logic        [mcr_pkg::MaskW-1:0]     in_mask;
	logic        [mcr_pkg::ColorW-1:0]    in_color;

	assign in_op    = s_axis_tuser;
	assign in_cx    = s_axis_tdata[15:0];
	assign in_cy    = s_axis_tdata[31:16];
	assign in_r     = s_axis_tdata[46:32];
	assign in_mask  = s_axis_tdata[50:47];
	assign in_color = s_axis_tdata[82:51];

	// Drawing state.
	mcr_pkg::state_t                       state_q;
	logic                                  active_q;
	logic signed [mcr_pkg::RadiusW-1:0]    step_x_q;
	logic signed [mcr_pkg::RadiusW-1:0]    step_y_q;
	logic signed [mcr_pkg::DecisionW-1:0]  decision_q;
	logic signed [mcr_pkg::GradXW-1:0]     grad_x_q;
	logic signed [mcr_pkg::GradYW-1:0]     grad_y_q;
	logic signed [mcr_pkg::CoordW-1:0]     saved_cx_q;
	logic signed [mcr_pkg::CoordW-1:0]     saved_cy_q;
	logic        [mcr_pkg::ColorW-1:0]     saved_color_q;
	logic        [mcr_pkg::MaskW:0]        saved_mask_q;

	// Result sequencer state.
	logic                          sts_pend_q;
	logic [1:0]                    sts_code_q;
	logic [mcr_pkg::NumSlots-1:0]  pix_pend_q;
	mcr_pkg::tbl_t                 tbl_q;

	// Output register.
	logic        o_valid_q;
	logic [71:0] o_data_q;
	logic [1:0]  o_user_q;
	logic        o_last_q;

	logic in_fire;
	logic load;

	assign s_axis_tready = (state_q == mcr_pkg::ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign load          = (state_q == mcr_pkg::ST_EMIT) && (!o_valid_q || m_axis_tready);

	// One midpoint iteration, applied when a step beat is accepted.
	logic                                  d_nonneg;
	logic signed [mcr_pkg::GradYW-1:0]     gy_inc;
	logic signed [mcr_pkg::GradXW-1:0]     gx_inc;
	logic signed [mcr_pkg::DecisionW-1:0]  d_mid;
	logic signed [mcr_pkg::DecisionW-1:0]  d_new;
	logic signed [mcr_pkg::RadiusW-1:0]    y_new;
	logic signed [mcr_pkg::GradYW-1:0]     gy_new;
	logic                                  step_over;

	always_comb begin
		d_nonneg  = !decision_q[mcr_pkg::DecisionW-1];
		gy_inc    = grad_y_q + 17'sd2;
		gx_inc    = grad_x_q + 16'sd2;
		d_mid     = d_nonneg ? (decision_q + mcr_pkg::DecisionW'(gy_inc)) : decision_q;
		d_new     = d_mid + mcr_pkg::DecisionW'(gx_inc);
		y_new     = d_nonneg ? (step_y_q - 15'sd1) : step_y_q;
		gy_new    = d_nonneg ? gy_inc : grad_y_q;
		step_over = !active_q || (step_x_q >= step_y_q);
	end

	// Start values derived from the incoming radius.
	logic signed [mcr_pkg::DecisionW-1:0]  d_start;
	logic signed [mcr_pkg::GradYW-1:0]     gy_start;

	always_comb begin
		d_start  = 18'sd1 - mcr_pkg::DecisionW'(in_r);
		gy_start = 17'sd0 - $signed({1'b0, in_r, 1'b0});
	end

	// Beat acceptance: update the drawing state and queue the results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			step_x_q      <= '0;
			step_y_q      <= '0;
			decision_q    <= '0;
			grad_x_q      <= 16'sd1;
			grad_y_q      <= '0;
			saved_cx_q    <= '0;
			saved_cy_q    <= '0;
			saved_color_q <= '0;
			saved_mask_q  <= '0;
		end else if (in_fire) begin
			case (in_op)
				mcr_pkg::OP_START_FULL, mcr_pkg::OP_START_CORNER: begin
					if (in_r[mcr_pkg::RadiusW-1]) begin
						active_q <= 1'b0;
					end else begin
						saved_cx_q    <= in_cx;
						saved_cy_q    <= in_cy;
						saved_color_q <= in_color;
						saved_mask_q  <= {(in_op == mcr_pkg::OP_START_FULL), in_mask};
						step_x_q      <= '0;
						step_y_q      <= in_r;
						decision_q    <= d_start;
						grad_x_q      <= 16'sd1;
						grad_y_q      <= gy_start;
						active_q      <= 1'b1;
					end
				end
				mcr_pkg::OP_STEP: begin
					if (step_over) begin
						active_q <= 1'b0;
					end else begin
						step_x_q   <= step_x_q + 15'sd1;
						step_y_q   <= y_new;
						grad_x_q   <= gx_inc;
						grad_y_q   <= gy_new;
						decision_q <= d_new;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Lowest pending pixel slot and the octant it draws.
	logic [2:0]                    slot;
	logic [mcr_pkg::NumSlots-1:0]  slot_bit;
	mcr_pkg::oct_t                 oct;

	always_comb begin
		slot     = 3'd0;
		slot_bit = '0;
		for (int i = mcr_pkg::NumSlots - 1; i >= 0; i--) begin
			if (pix_pend_q[i]) begin
				slot = 3'(i);
			end
		end
		slot_bit[slot] = 1'b1;
		oct = mcr_pkg::slot_oct(tbl_q, slot);
	end

	// Shared coordinate unit: one mirrored pixel per cycle while the output register can load.
	logic signed [mcr_pkg::PixW-1:0] off_a;
	logic signed [mcr_pkg::PixW-1:0] off_b;
	logic signed [mcr_pkg::PixW-1:0] pix_x;
	logic signed [mcr_pkg::PixW-1:0] pix_y;

	always_comb begin
		off_a = mcr_pkg::PixW'(oct.swap ? step_y_q : step_x_q);
		off_b = mcr_pkg::PixW'(oct.swap ? step_x_q : step_y_q);
		pix_x = mcr_pkg::PixW'(saved_cx_q) + (oct.neg_a ? -off_a : off_a);
		pix_y = mcr_pkg::PixW'(saved_cy_q) + (oct.neg_b ? -off_b : off_b);
	end

	// Sequencer: queue results on acceptance, drain one per output slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mcr_pkg::ST_IDLE;
			sts_pend_q <= 1'b0;
			sts_code_q <= mcr_pkg::STS_PIXEL;
			pix_pend_q <= '0;
			tbl_q      <= mcr_pkg::TBL_AXIS;
		end else if (in_fire) begin
			case (in_op)
				mcr_pkg::OP_START_FULL, mcr_pkg::OP_START_CORNER: begin
					state_q    <= mcr_pkg::ST_EMIT;
					sts_pend_q <= 1'b1;
					tbl_q      <= mcr_pkg::TBL_AXIS;
					if (in_r[mcr_pkg::RadiusW-1]) begin
						sts_code_q <= mcr_pkg::STS_BADR;
						pix_pend_q <= '0;
					end else begin
						sts_code_q <= mcr_pkg::STS_START;
						pix_pend_q <= (in_op == mcr_pkg::OP_START_FULL) ? 8'h0F : 8'h00;
					end
				end
				mcr_pkg::OP_STEP: begin
					if (step_over) begin
						state_q    <= mcr_pkg::ST_EMIT;
						sts_pend_q <= 1'b1;
						sts_code_q <= mcr_pkg::STS_DONE;
						pix_pend_q <= '0;
					end else if (saved_mask_q[mcr_pkg::MaskW]) begin
						state_q    <= mcr_pkg::ST_EMIT;
						sts_pend_q <= 1'b0;
						tbl_q      <= mcr_pkg::TBL_FULL;
						pix_pend_q <= 8'hFF;
					end else begin
						// Quadrant pairs in emission order: lower-right, upper-right,
						// lower-left, upper-left.
						state_q    <= (saved_mask_q[3:0] != 4'd0) ? mcr_pkg::ST_EMIT
						                                           : mcr_pkg::ST_IDLE;
						sts_pend_q <= 1'b0;
						tbl_q      <= mcr_pkg::TBL_CORNER;
						pix_pend_q <= {{2{saved_mask_q[0]}}, {2{saved_mask_q[3]}},
						               {2{saved_mask_q[1]}}, {2{saved_mask_q[2]}}};
					end
				end
				default: begin
				end
			endcase
		end else if (load) begin
			if (sts_pend_q) begin
				sts_pend_q <= 1'b0;
				if (pix_pend_q == '0) begin
					state_q <= mcr_pkg::ST_IDLE;
				end
			end else begin
				pix_pend_q <= pix_pend_q & ~slot_bit;
				if ((pix_pend_q & ~slot_bit) == '0) begin
					state_q <= mcr_pkg::ST_IDLE;
				end
			end
		end
	end

	// Output register: valid control under reset, payload loaded on demand.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (load) begin
			o_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sts_pend_q) begin
				o_data_q <= {6'd0, saved_color_q, 34'd0};
				o_user_q <= sts_code_q;
				o_last_q <= (pix_pend_q == '0);
			end else begin
				o_data_q <= {6'd0, saved_color_q, pix_y, pix_x};
				o_user_q <= mcr_pkg::STS_PIXEL;
				o_last_q <= ((pix_pend_q & ~slot_bit) == '0);
			end
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tdata  = o_data_q;
	assign m_axis_tuser  = o_user_q;
	assign m_axis_tlast  = o_last_q;

	// Checks on the sequencer.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!sts_pend_q && (pix_pend_q == '0)))
		else $error("input ready while results are still queued");

	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mcr_pkg::ST_EMIT) |-> (sts_pend_q || (pix_pend_q != '0)))
		else $error("emitting with nothing queued");

	a_pixel_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !sts_pend_q) |=>
		($countones(pix_pend_q) == $countones($past(pix_pend_q)) - 1))
		else $error("pixel queue did not drop by one beat");

	a_status_zero_xy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != mcr_pkg::STS_PIXEL)) |->
		(m_axis_tdata[33:0] == 34'd0))
		else $error("status beat carries nonzero coordinates");

endmodule
